>>> hw/rtl/tvbc_pkg.sv
// ----------------------------------------------------------------------------
// tvbc_pkg
// Shared types, register indexes, reset keys and the half-round mix functions
// of the modified 64-bit TEA block cipher.
// ----------------------------------------------------------------------------
package tvbc_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CFG_IDX_W = 3;

    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_KEY_WORD0    = 3'd0;
    localparam cfg_index_t REG_KEY_WORD1    = 3'd1;
    localparam cfg_index_t REG_KEY_WORD2    = 3'd2;
    localparam cfg_index_t REG_KEY_WORD3    = 3'd3;
    localparam cfg_index_t REG_ENCRYPT_MODE = 3'd4;

    localparam word_t TEA_DELTA = 32'h9E37_79B9;

    localparam word_t KEY_WORD0_RST = 32'h4C7A_DF03;
    localparam word_t KEY_WORD1_RST = 32'h5F30_E75F;
    localparam word_t KEY_WORD2_RST = 32'h1D14_9820;
    localparam word_t KEY_WORD3_RST = 32'h0398_5ADF;

    function automatic word_t mix_first(word_t w, word_t sum, word_t k0, word_t k1);
        return ((w << 4) - k0) ^ (w + sum) ^ ((w >> 5) + k1);
    endfunction

    function automatic word_t mix_second(word_t w, word_t sum, word_t k2, word_t k3);
        return ((w << 4) - k2) ^ (w + sum) ^ ((w >> 5) - k3);
    endfunction

endpackage

>>> hw/rtl/tea_variant_block_cipher.sv
// ----------------------------------------------------------------------------
// tea_variant_block_cipher
// Pipelined modified-TEA block cipher, one full round per register stage.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   s_first_word, s_second_word, s_last_block
//  m_        out        m_valid / m_ready   m_first_out, m_second_out, m_last_out
//  cfg_      in         cfg_we              cfg_index, cfg_wdata
//
//  Each block passes through one registered stage per round from request to result;
//  one block enters per cycle while s_ready is high. Each stage holds one cipher round:
//  two dependent mix/add half-rounds. A stalled output holds the last stage; empty stages
//  upstream still fill. Synchronous active-low reset empties every stage, loads the
//  default key and selects decrypt mode.
module tea_variant_block_cipher #(
    parameter int unsigned ROUND_COUNT = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  tvbc_pkg::cfg_index_t  cfg_index,
    input  tvbc_pkg::word_t       cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  tvbc_pkg::word_t       s_first_word,
    input  tvbc_pkg::word_t       s_second_word,
    input  logic                  s_last_block,

    output logic                  m_valid,
    input  logic                  m_ready,
    output tvbc_pkg::word_t       m_first_out,
    output tvbc_pkg::word_t       m_second_out,
    output logic                  m_last_out
);

    import tvbc_pkg::*;

    word_t key_word0_reg;
    word_t key_word1_reg;
    word_t key_word2_reg;
    word_t key_word3_reg;
    logic  encrypt_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_word0_reg    <= KEY_WORD0_RST;
            key_word1_reg    <= KEY_WORD1_RST;
            key_word2_reg    <= KEY_WORD2_RST;
            key_word3_reg    <= KEY_WORD3_RST;
            encrypt_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_KEY_WORD0:    key_word0_reg    <= cfg_wdata;
                REG_KEY_WORD1:    key_word1_reg    <= cfg_wdata;
                REG_KEY_WORD2:    key_word2_reg    <= cfg_wdata;
                REG_KEY_WORD3:    key_word3_reg    <= cfg_wdata;
                REG_ENCRYPT_MODE: encrypt_mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic  valid_reg  [ROUND_COUNT];
    word_t a_reg      [ROUND_COUNT];
    word_t b_reg      [ROUND_COUNT];
    logic  last_reg   [ROUND_COUNT];

    logic  stage_ready [ROUND_COUNT+1];
    logic  in_valid    [ROUND_COUNT];
    word_t in_a        [ROUND_COUNT];
    word_t in_b        [ROUND_COUNT];
    logic  in_last     [ROUND_COUNT];
    word_t a_next      [ROUND_COUNT];
    word_t b_next      [ROUND_COUNT];

    assign stage_ready[ROUND_COUNT] = m_ready;

    genvar r;
    generate
        for (r = 0; r < ROUND_COUNT; r++) begin : g_round
            localparam word_t SUM_ENC = 32'(64'(TEA_DELTA) * 64'(r + 1));
            localparam word_t SUM_DEC = 32'(64'(TEA_DELTA) * 64'(ROUND_COUNT - r));

            word_t enc_a;
            word_t enc_b;
            word_t dec_a;
            word_t dec_b;

            if (r == 0) begin : g_head
                assign in_valid[r] = s_valid;
                assign in_a[r]     = s_first_word;
                assign in_b[r]     = s_second_word;
                assign in_last[r]  = s_last_block;
            end else begin : g_body
                assign in_valid[r] = valid_reg[r-1];
                assign in_a[r]     = a_reg[r-1];
                assign in_b[r]     = b_reg[r-1];
                assign in_last[r]  = last_reg[r-1];
            end

            assign stage_ready[r] = !valid_reg[r] || stage_ready[r+1];

            always_comb begin
                enc_a = in_a[r] + mix_first(in_b[r], SUM_ENC, key_word0_reg, key_word1_reg);
                enc_b = in_b[r] + mix_second(enc_a, SUM_ENC, key_word2_reg, key_word3_reg);
                dec_b = in_b[r] - mix_second(in_a[r], SUM_DEC, key_word2_reg, key_word3_reg);
                dec_a = in_a[r] - mix_first(dec_b, SUM_DEC, key_word0_reg, key_word1_reg);
                a_next[r] = encrypt_mode_reg ? enc_a : dec_a;
                b_next[r] = encrypt_mode_reg ? enc_b : dec_b;
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[r] <= 1'b0;
                end else if (stage_ready[r]) begin
                    valid_reg[r] <= in_valid[r];
                end
            end

            always_ff @(posedge aclk) begin
                if (stage_ready[r] && in_valid[r]) begin
                    a_reg[r]    <= a_next[r];
                    b_reg[r]    <= b_next[r];
                    last_reg[r] <= in_last[r];
                end
            end
        end
    endgenerate

    assign s_ready      = stage_ready[0];
    assign m_valid      = valid_reg[ROUND_COUNT-1];
    assign m_first_out  = a_reg[ROUND_COUNT-1];
    assign m_second_out = b_reg[ROUND_COUNT-1];
    assign m_last_out   = last_reg[ROUND_COUNT-1];

endmodule

>>> hw/rtl/tvbc_checker.sv
// ----------------------------------------------------------------------------
// tvbc_checker
// Port-level checks on reset, back-pressure and output hold of the cipher.
// ----------------------------------------------------------------------------
module tvbc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_first_out,
    input  logic [31:0] m_second_out,
    input  logic        m_last_out
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_first_out)
            && $stable(m_second_out) && $stable(m_last_out))
        else $error("stalled result changed or dropped");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready right after reset");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input blocked without a stalled result");

endmodule

bind tea_variant_block_cipher tvbc_checker u_tvbc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_first_out  (m_first_out),
    .m_second_out (m_second_out),
    .m_last_out   (m_last_out)
);

>>> dv/tb_tea_variant_block_cipher.sv
// ----------------------------------------------------------------------------
// tb_tea_variant_block_cipher
// Drives 64-bit blocks through the modified-TEA cipher under several key and
// mode settings. Each accepted block is enciphered or deciphered by an
// in-bench predictor, and every result is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_tea_variant_block_cipher;

    timeunit 1ns;
    timeprecision 1ps;

    import tvbc_pkg::*;

    localparam int unsigned ROUNDS = 32;

    typedef struct packed {
        word_t first;
        word_t second;
        logic  last;
    } block_t;

    class cipher_scoreboard;
        word_t        key_words[4];
        bit           encrypt;
        block_t       expected_q[$];
        int unsigned  error_count;

        function new();
            key_words[0] = KEY_WORD0_RST;
            key_words[1] = KEY_WORD1_RST;
            key_words[2] = KEY_WORD2_RST;
            key_words[3] = KEY_WORD3_RST;
            encrypt      = 1'b0;
            error_count  = 0;
        endfunction

        function void apply_write(cfg_index_t idx, word_t data);
            case (idx)
                REG_KEY_WORD0:    key_words[0] = data;
                REG_KEY_WORD1:    key_words[1] = data;
                REG_KEY_WORD2:    key_words[2] = data;
                REG_KEY_WORD3:    key_words[3] = data;
                REG_ENCRYPT_MODE: encrypt = data[0];
                default: ;
            endcase
        endfunction

        function block_t transform(block_t blk);
            word_t  a;
            word_t  b;
            word_t  sum;
            block_t res;
            a = blk.first;
            b = blk.second;
            if (encrypt) begin
                sum = '0;
                repeat (ROUNDS) begin
                    sum = sum + TEA_DELTA;
                    a = a + (((b << 4) - key_words[0]) ^ (b + sum) ^ ((b >> 5) + key_words[1]));
                    b = b + (((a << 4) - key_words[2]) ^ (a + sum) ^ ((a >> 5) - key_words[3]));
                end
            end else begin
                sum = '0;
                repeat (ROUNDS) sum = sum + TEA_DELTA;
                repeat (ROUNDS) begin
                    b = b - (((a << 4) - key_words[2]) ^ (a + sum) ^ ((a >> 5) - key_words[3]));
                    a = a - (((b << 4) - key_words[0]) ^ (b + sum) ^ ((b >> 5) + key_words[1]));
                    sum = sum - TEA_DELTA;
                end
            end
            res.first  = a;
            res.second = b;
            res.last   = blk.last;
            return res;
        endfunction

        function void note_request(block_t blk);
            expected_q.push_back(transform(blk));
        endfunction

        function void check_result(block_t got);
            block_t exp_blk;
            if (expected_q.size() == 0) begin
                $error("unexpected result: first_out %h second_out %h last_out %b",
                       got.first, got.second, got.last);
                error_count++;
                return;
            end
            exp_blk = expected_q.pop_front();
            if (got.first !== exp_blk.first) begin
                $error("first_out: expected %h, actual %h", exp_blk.first, got.first);
                error_count++;
            end
            if (got.second !== exp_blk.second) begin
                $error("second_out: expected %h, actual %h", exp_blk.second, got.second);
                error_count++;
            end
            if (got.last !== exp_blk.last) begin
                $error("last_out: expected %b, actual %b", exp_blk.last, got.last);
                error_count++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic       aclk;
    logic       aresetn       = 1'b0;
    logic       cfg_we        = 1'b0;
    cfg_index_t cfg_index     = '0;
    word_t      cfg_wdata     = '0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    word_t      s_first_word  = '0;
    word_t      s_second_word = '0;
    logic       s_last_block  = 1'b0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    word_t      m_first_out;
    word_t      m_second_out;
    logic       m_last_out;

    int unsigned send_idle_pct = 12;
    int unsigned recv_idle_pct = 70;

    cipher_scoreboard sb = new();

    tea_variant_block_cipher #(
        .ROUND_COUNT (ROUNDS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_first_word  (s_first_word),
        .s_second_word (s_second_word),
        .s_last_block  (s_last_block),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_first_out   (m_first_out),
        .m_second_out  (m_second_out),
        .m_last_out    (m_last_out)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result({m_first_out, m_second_out, m_last_out});
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(cfg_index_t idx, word_t data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.apply_write(idx, data);
    endtask

    task automatic set_keys(word_t k0, word_t k1, word_t k2, word_t k3);
        cfg_write(REG_KEY_WORD0, k0);
        cfg_write(REG_KEY_WORD1, k1);
        cfg_write(REG_KEY_WORD2, k2);
        cfg_write(REG_KEY_WORD3, k3);
    endtask

    task automatic set_mode(bit enc);
        word_t data;
        data    = $urandom();
        data[0] = enc;
        cfg_write(REG_ENCRYPT_MODE, data);
    endtask

    task automatic send_blocks(input block_t blocks[$], input int pause_at);
        bit holding;
        holding = 1'b0;
        @(posedge aclk);
        for (int i = 0; i < blocks.size(); i++) begin
            if (!holding) begin
                do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
            end
            s_valid       <= 1'b1;
            s_first_word  <= blocks[i].first;
            s_second_word <= blocks[i].second;
            s_last_block  <= blocks[i].last;
            do @(posedge aclk); while (!s_ready);
            sb.note_request(blocks[i]);
            holding = (i + 1 < blocks.size()) && (i != pause_at)
                      && ($urandom_range(99) >= send_idle_pct);
            if (!holding) s_valid <= 1'b0;
            if (i == pause_at) wait_drained();
        end
    endtask

    function automatic block_t random_block();
        block_t blk;
        case ($urandom_range(9))
            0:       blk.first = '0;
            1:       blk.first = '1;
            default: blk.first = $urandom();
        endcase
        case ($urandom_range(9))
            0:       blk.second = '0;
            1:       blk.second = '1;
            default: blk.second = $urandom();
        endcase
        blk.last = ($urandom_range(3) == 0);
        return blk;
    endfunction

    initial begin
        block_t plain_q[$];
        block_t cipher_q[$];
        block_t rand_q[$];
        bit     enc;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // default key, decrypt after reset
        plain_q = '{'{32'h0000_0000, 32'h0000_0000, 1'b0},
                    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1},
                    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0},
                    '{32'h8000_0000, 32'h0000_0001, 1'b1}};
        send_blocks(plain_q, -1);

        // encrypt, then decrypt the same blocks to get the plaintext back
        wait_drained();
        set_mode(1'b1);
        plain_q.push_back(random_block());
        plain_q.push_back(random_block());
        cipher_q.delete();
        foreach (plain_q[i]) cipher_q.push_back(sb.transform(plain_q[i]));
        send_blocks(plain_q, -1);

        wait_drained();
        cfg_write(REG_ENCRYPT_MODE, 32'hFFFF_FFFE);
        cfg_write(cfg_index_t'(5), $urandom());
        cfg_write(cfg_index_t'(6), $urandom());
        cfg_write(cfg_index_t'(7), $urandom());
        send_blocks(cipher_q, -1);

        wait_drained();
        set_keys('0, '0, '0, '0);
        set_mode(1'b1);
        send_blocks('{'{32'h0000_0000, 32'h0000_0000, 1'b1},
                      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0}}, -1);

        wait_drained();
        set_keys('1, '1, '1, '1);
        set_mode(1'b0);
        send_blocks('{'{32'h0000_0000, 32'hFFFF_FFFF, 1'b0},
                      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}}, -1);

        for (int p = 0; p < 6; p++) begin
            wait_drained();
            case (p / 2)
                0:       begin send_idle_pct = 12; recv_idle_pct = 70; end
                1:       begin send_idle_pct = 70; recv_idle_pct = 12; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            case (p)
                0:       set_keys('0, '0, '0, '0);
                1:       set_keys('1, '1, '1, '1);
                4:       set_keys(KEY_WORD0_RST, KEY_WORD1_RST, KEY_WORD2_RST, KEY_WORD3_RST);
                default: set_keys($urandom(), $urandom(), $urandom(), $urandom());
            endcase
            enc = (p == 5) ? 1'($urandom_range(1)) : (p % 2 == 0);
            set_mode(enc);
            rand_q.delete();
            repeat (150) rand_q.push_back(random_block());
            send_blocks(rand_q, (p == 0) ? $urandom_range(20, 130) : -1);
        end

        wait_drained();
        repeat (ROUNDS + 8) @(posedge aclk);
        if (sb.error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #400_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
